// ===== src/cts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the C token scanner
// Token codes, keyword table and the request record passed front to back.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int MaxKeywordLen = 14;
    localparam int OffsetBits    = 32;
    localparam int LengthBits    = 16;
    localparam int ValueBits     = 63;
    localparam int NumKeywords   = 44;

    localparam logic [5:0] CODE_IDENT   = 6'd44;
    localparam logic [5:0] CODE_NUMBER  = 6'd45;
    localparam logic [5:0] CODE_PUNCT0  = 6'd46;
    localparam logic [5:0] CODE_NEWLINE = 6'd57;
    localparam logic [5:0] CODE_UNKNOWN = 6'd58;

    localparam logic [ValueBits-1:0] VALUE_MAX = {ValueBits{1'b1}};
    localparam logic [LengthBits-1:0] LENGTH_MAX = {LengthBits{1'b1}};

    typedef logic [MaxKeywordLen*8-1:0] word_t;

    // One token request: at most two tokens per character.
    typedef struct packed {
        logic [5:0]            tok_code;
        logic [OffsetBits-1:0] token_start;
        logic [LengthBits-1:0] token_length;
        logic [ValueBits-1:0]  number_value;
    } token_t;

    typedef struct packed {
        logic   first_vld;
        token_t first;
        logic   second_vld;
        token_t second;
    } req_t;

    // Keyword text packed low byte first, padded with zeros.
    function automatic word_t kw_text(input int idx);
        string s;
        word_t w;
        s = "";
        w = '0;
        case (idx)
            0: s = "auto";        1: s = "break";      2: s = "case";
            3: s = "char";        4: s = "const";      5: s = "continue";
            6: s = "default";     7: s = "do";         8: s = "double";
            9: s = "else";        10: s = "enum";      11: s = "extern";
            12: s = "float";      13: s = "for";       14: s = "goto";
            15: s = "if";         16: s = "inline";    17: s = "int";
            18: s = "long";       19: s = "register";  20: s = "restrict";
            21: s = "return";     22: s = "short";     23: s = "signed";
            24: s = "sizeof";     25: s = "static";    26: s = "struct";
            27: s = "switch";     28: s = "typedef";   29: s = "union";
            30: s = "unsigned";   31: s = "void";      32: s = "volatile";
            33: s = "while";      34: s = "_Alignas";  35: s = "_Alignof";
            36: s = "_Atomic";    37: s = "_Bool";     38: s = "_Complex";
            39: s = "_Generic";   40: s = "_Imaginary"; 41: s = "_Noreturn";
            42: s = {"_Static", "_assert"};
            43: s = "_Thread_local";
            default: s = "";
        endcase
        for (int i = 0; i < MaxKeywordLen; i++) begin
            if (i < s.len()) begin
                w[i*8 +: 8] = s[i];
            end
        end
        return w;
    endfunction

    function automatic int kw_len(input int idx);
        word_t w;
        int    n;
        w = kw_text(idx);
        n = 0;
        for (int i = 0; i < MaxKeywordLen; i++) begin
            if (w[i*8 +: 8] != 8'd0) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/cts_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cts_front: character classifier and token tracker
// Takes one character per cycle while the queue is not full, keeps the open
// word or number and pushes token requests to the queue.
// ----------------------------------------------------------------------------
module cts_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_ch,
    output logic                           push,
    output cts_pkg::req_t                  push_req,
    input  wire logic                      q_full
);
    import cts_pkg::*;

    typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_NUM} mode_t;

    mode_t                  mode_reg, mode_next;
    word_t                  word_reg, word_next;
    logic [LengthBits-1:0]  len_reg, len_next;
    logic [ValueBits-1:0]   acc_reg, acc_next;
    logic [OffsetBits-1:0]  start_reg, start_next;
    logic [OffsetBits-1:0]  off_reg, off_next;

    logic is_alpha, is_digit, is_us, cont_word, fire;
    logic [3:0] digit;
    logic [ValueBits+3:0] acc_x10;
    logic [5:0] kw_code, single_code;
    token_t open_tok, single_tok;
    logic closes, single_vld;

    assign s_ready = !q_full;
    assign fire = s_valid && s_ready;

    assign is_alpha = (s_ch >= 8'h61 && s_ch <= 8'h7a) || (s_ch >= 8'h41 && s_ch <= 8'h5a);
    assign is_digit = (s_ch >= 8'h30 && s_ch <= 8'h39);
    assign is_us = (s_ch == 8'h5f);
    assign cont_word = is_alpha || is_digit || is_us;
    assign digit = s_ch[3:0];
    assign acc_x10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {{ValueBits{1'b0}}, digit};

    // Keyword match against the stored first characters.
    always_comb begin
        kw_code = CODE_IDENT;
        for (int k = NumKeywords - 1; k >= 0; k--) begin
            if (len_reg == LengthBits'(kw_len(k))) begin
                if ((word_reg & ((word_t'(1) << (8 * kw_len(k))) - word_t'(1)))
                        == kw_text(k)) begin
                    kw_code = 6'(k);
                end
            end
        end
    end

    always_comb begin
        single_code = CODE_UNKNOWN;
        unique case (s_ch)
            8'h0a: single_code = CODE_NEWLINE;
            8'h28: single_code = CODE_PUNCT0;
            8'h29: single_code = CODE_PUNCT0 + 6'd1;
            8'h7b: single_code = CODE_PUNCT0 + 6'd2;
            8'h7d: single_code = CODE_PUNCT0 + 6'd3;
            8'h3b: single_code = CODE_PUNCT0 + 6'd4;
            8'h5b: single_code = CODE_PUNCT0 + 6'd5;
            8'h5d: single_code = CODE_PUNCT0 + 6'd6;
            8'h2b: single_code = CODE_PUNCT0 + 6'd7;
            8'h2d: single_code = CODE_PUNCT0 + 6'd8;
            8'h2a: single_code = CODE_PUNCT0 + 6'd9;
            8'h2f: single_code = CODE_PUNCT0 + 6'd10;
            default: single_code = CODE_UNKNOWN;
        endcase
    end

    always_comb begin
        mode_next  = mode_reg;
        word_next  = word_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        start_next = start_reg;
        off_next   = off_reg;
        closes     = 1'b0;
        single_vld = 1'b0;

        open_tok.tok_code     = (mode_reg == MODE_NUM) ? CODE_NUMBER : kw_code;
        open_tok.token_start  = start_reg;
        open_tok.token_length = len_reg;
        open_tok.number_value = (mode_reg == MODE_NUM) ? acc_reg : '0;
        if (mode_reg == MODE_WORD && len_reg > LengthBits'(MaxKeywordLen)) begin
            open_tok.tok_code = CODE_IDENT;
        end

        single_tok.tok_code     = single_code;
        single_tok.token_start  = off_reg;
        single_tok.token_length = LengthBits'(1);
        single_tok.number_value = '0;

        if (fire) begin
            if (mode_reg == MODE_WORD && cont_word) begin
                for (int i = 0; i < MaxKeywordLen; i++) begin
                    if (len_reg == LengthBits'(i)) begin
                        word_next[i*8 +: 8] = s_ch;
                    end
                end
                if (len_reg != LENGTH_MAX) len_next = len_reg + 1'b1;
                off_next = off_reg + 1'b1;
            end else if (mode_reg == MODE_NUM && is_digit) begin
                if (acc_x10[ValueBits+3:ValueBits] != 4'd0) acc_next = VALUE_MAX;
                else acc_next = acc_x10[ValueBits-1:0];
                if (len_reg != LENGTH_MAX) len_next = len_reg + 1'b1;
                off_next = off_reg + 1'b1;
            end else begin
                closes    = (mode_reg != MODE_IDLE);
                mode_next = MODE_IDLE;
                if (s_ch == 8'd0) begin
                    off_next = '0;
                end else begin
                    off_next = off_reg + 1'b1;
                    if (s_ch == 8'h20 || s_ch == 8'h09) begin
                        // skip blanks
                    end else if (is_alpha || is_us) begin
                        mode_next  = MODE_WORD;
                        word_next[7:0] = s_ch;
                        len_next   = LengthBits'(1);
                        start_next = off_reg;
                    end else if (is_digit) begin
                        mode_next  = MODE_NUM;
                        acc_next   = ValueBits'(digit);
                        len_next   = LengthBits'(1);
                        start_next = off_reg;
                    end else begin
                        single_vld = 1'b1;
                    end
                end
            end
        end

        push = closes || single_vld;
        push_req.first_vld  = 1'b1;
        push_req.first      = closes ? open_tok : single_tok;
        push_req.second_vld = closes && single_vld;
        push_req.second     = single_tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            len_reg   <= '0;
            acc_reg   <= '0;
            start_reg <= '0;
            off_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            start_reg <= start_next;
            off_reg   <= off_next;
        end
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

// ===== src/cts_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cts_queue: short request queue between front and back
// Four entries; full is raised at three held requests, one entry still free.
// ----------------------------------------------------------------------------
module cts_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire cts_pkg::req_t push_req,
    output logic               full,
    output logic               not_empty,
    output cts_pkg::req_t      head_req,
    input  wire logic          pop
);
    import cts_pkg::*;

    req_t       mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;

    assign full      = (cnt_reg >= 3'd3);
    assign not_empty = (cnt_reg != 3'd0);
    assign head_req  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
        if (push) mem_reg[wr_reg] <= push_req;
    end

endmodule

`default_nettype wire

// ===== src/cts_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cts_back: token emitter
// Sends the one or two tokens of each request through a registered output.
// ----------------------------------------------------------------------------
module cts_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_not_empty,
    input  wire cts_pkg::req_t                   head_req,
    output logic                                 pop,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [5:0]                           m_tok_code,
    output logic [cts_pkg::OffsetBits-1:0]       m_token_start,
    output logic [cts_pkg::LengthBits-1:0]       m_token_length,
    output logic [cts_pkg::ValueBits-1:0]        m_number_value,
    output logic                                 m_last_of_run
);
    import cts_pkg::*;

    logic   valid_reg, last_reg, half_reg;
    token_t tok_reg;
    logic   load;
    token_t tok_sel;
    logic   last_sel;

    assign load = q_not_empty && (!valid_reg || m_ready);
    // Advance to the second token or release the request.
    assign pop  = load && (half_reg || !head_req.second_vld);
    assign tok_sel  = half_reg ? head_req.second : head_req.first;
    assign last_sel = half_reg || !head_req.second_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                half_reg  <= !pop;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
        if (load) begin
            tok_reg  <= tok_sel;
            last_reg <= last_sel;
        end
    end

    assign m_valid        = valid_reg;
    assign m_tok_code     = tok_reg.tok_code;
    assign m_token_start  = tok_reg.token_start;
    assign m_token_length = tok_reg.token_length;
    assign m_number_value = tok_reg.number_value;
    assign m_last_of_run  = last_reg;

endmodule

`default_nettype wire

// ===== src/c_token_scanner_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c_token_scanner_top: streaming C lexer, one character per request
// Usage:
//   s_valid/s_ready/s_ch carry source characters; a request is accepted
//   when valid and ready are both high. ch = 0 ends the text, flushes any
//   open word or number and restarts the offset at zero.
//   m_valid/m_ready carry tokens: code, start offset, length, value, and
//   last_of_run on the final token caused by one character.
// Path: the request for a token is written into the queue, then moved to the back end's output register.
// Throughput: one character per cycle while s_ready is high; a character that closes a token and
//   is itself a token yields two tokens, sent one after the other by the back end.
//   The output port, one token per cycle while m_ready is high, sets the sustained limit.
// Stall: a four-entry request queue absorbs output back-pressure; s_ready
//   drops when it has one free entry or less.
// Reset: synchronous active-low aresetn empties the queue and output,
//   and returns the scanner to idle at offset zero.
// ----------------------------------------------------------------------------
module c_token_scanner_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_ch,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [5:0]                           m_tok_code,
    output logic [cts_pkg::OffsetBits-1:0]       m_token_start,
    output logic [cts_pkg::LengthBits-1:0]       m_token_length,
    output logic [cts_pkg::ValueBits-1:0]        m_number_value,
    output logic                                 m_last_of_run
);
    import cts_pkg::*;

    logic push, q_full, q_not_empty, pop;
    req_t push_req, head_req;

    // Classify characters and build token requests.
    cts_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_ch,
        .push, .push_req, .q_full
    );

    // Hold requests while the output stalls.
    cts_queue u_queue (
        .aclk, .aresetn, .push, .push_req,
        .full(q_full), .not_empty(q_not_empty), .head_req, .pop
    );

    // Drain requests one token per cycle while the output is ready.
    cts_back u_back (
        .aclk, .aresetn, .q_not_empty, .head_req, .pop,
        .m_valid, .m_ready, .m_tok_code, .m_token_start,
        .m_token_length, .m_number_value, .m_last_of_run
    );

endmodule

`default_nettype wire
